// ----- src/rau_pkg.sv -----
`default_nettype none
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_ABS = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [1:0] FLT_OK   = 2'd0;
  localparam logic [1:0] FLT_ZERO = 2'd1;
  localparam logic [1:0] FLT_OVF  = 2'd2;

  localparam int unsigned DW = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FORM,
    ST_GCD,
    ST_GWAIT,
    ST_DNUM,
    ST_NWAIT,
    ST_DDEN,
    ST_DWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic           start;
    logic           want_quot;
    logic [DW-1:0]  dividend;
    logic [DW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [DW-1:0]  result;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- src/rau_div.sv -----
`default_nettype none
// signed truncating divide/remainder, one quotient bit per cycle
module rau_div
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          qneg_r, qneg_nxt;
  logic          rneg_r, rneg_nxt;
  logic          wq_r, wq_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [DW:0]   trial;
  logic [DW-1:0] shr;
  logic [DW-1:0] qres, rres;

  always_comb begin
    shr   = {rem_r[DW-2:0], quo_r[DW-1]};
    trial = {1'b0, shr} - {1'b0, dvs_r};
    qres  = qneg_r ? -quo_r : quo_r;
    rres  = rneg_r ? -rem_r : rem_r;
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    wq_nxt   = wq_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = req.dividend[DW-1] ? -req.dividend : req.dividend;
      dvs_nxt  = req.divisor[DW-1] ? -req.divisor : req.divisor;
      qneg_nxt = req.dividend[DW-1] ^ req.divisor[DW-1];
      rneg_nxt = req.dividend[DW-1];
      wq_nxt   = req.want_quot;
      cnt_nxt  = 7'(DW);
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], ~trial[DW]};
      rem_nxt = trial[DW] ? shr : trial[DW-1:0];
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    wq_r   <= wq_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = wq_r ? qres : rres;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r)) else $error("div done without busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r) else $error("div busy after done");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 7'd0) else $error("div count lost");
`endif

endmodule
`default_nettype wire

// ----- src/rational_arithmetic_unit_top.sv -----
`default_nettype none
// channel  dir  tdata fields (lsb first)                         tuser
// in_      in   req_type[2:0] a_num b_num.. see port comment       -
// out_     out  res_num[63:0] res_den[127:64] order fault          -
// Compare, overflow and unused codes go from ST_FORM straight to ST_OUT, a zero
// gcd through ST_GCD; a reduced beat runs the Euclid loop (about 90 steps at
// most) and then two final divisions. Four 32x32 products share one multiplier
// (one per cycle); every Euclid step and both final divisions use one radix-2
// divider. Results sit in an output register; in_tready is low from acceptance
// until out beat leaves. rst_n is synchronous, active low, and clears only the
// sequencer state and the divider's busy, done and count registers.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // req_type[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res_num[63:0], res_den[127:64], order[129:128], fault[131:130]
  output logic [135:0]      out_tdata
);

  localparam int OW = OPERAND_WIDTH;

  state_t st_r, st_nxt;
  logic [2:0]    op_r;
  logic [DW-1:0] an_r, ad_r, bn_r, bd_r;
  logic [DW-1:0] p_r, q_r, d_r;
  logic [DW-1:0] x_r, y_r, num_r, den_r;
  logic [1:0]    ord_r, flt_r;
  logic [DW-1:0] ma, mb, prod;
  logic [DW-1:0] sum, dif;
  logic          ovf_add, ovf_sub;
  div_req_t      dreq;
  div_rsp_t      drsp;
  logic          op_ok;

  function automatic logic [DW-1:0] sx(input logic [31:0] v);
    logic [OW-1:0] t;
    t = v[OW-1:0];
    return {{(DW-OW){t[OW-1]}}, t};
  endfunction

  assign op_ok = (op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_MUL) ||
                 (op_r == OP_DIV) || (op_r == OP_ABS) || (op_r == OP_CMP);

  // shared multiplier operand select
  always_comb begin
    ma = an_r; mb = bd_r;
    case (st_r)
      ST_MUL1: begin ma = an_r; mb = bd_r; end
      ST_MUL2: begin ma = ad_r; mb = bn_r; end
      ST_MUL3: begin ma = ad_r; mb = bd_r; end
      ST_FORM: begin ma = an_r; mb = bn_r; end
      default: begin ma = an_r; mb = bd_r; end
    endcase
  end
  assign prod = DW'($signed(ma[31:0]) * $signed(mb[31:0]));
  assign sum  = p_r + q_r;
  assign dif  = p_r - q_r;
  assign ovf_add = (p_r[DW-1] == q_r[DW-1]) && (sum[DW-1] != p_r[DW-1]);
  assign ovf_sub = (p_r[DW-1] != q_r[DW-1]) && (dif[DW-1] != p_r[DW-1]);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_tvalid) st_nxt = ST_MUL1;
      ST_MUL1:  st_nxt = ST_MUL2;
      ST_MUL2:  st_nxt = ST_MUL3;
      ST_MUL3:  st_nxt = ST_FORM;
      ST_FORM: begin
        if (!op_ok || op_r == OP_CMP) st_nxt = ST_OUT;
        else if ((op_r == OP_ADD && ovf_add) || (op_r == OP_SUB && ovf_sub))
          st_nxt = ST_OUT;
        else st_nxt = ST_GCD;
      end
      ST_GCD: begin
        if (y_r != '0) st_nxt = ST_GWAIT;
        else if (x_r == '0) st_nxt = ST_OUT;
        else st_nxt = ST_DNUM;
      end
      ST_GWAIT: if (drsp.done) st_nxt = ST_GCD;
      ST_DNUM:  st_nxt = ST_NWAIT;
      ST_NWAIT: if (drsp.done) st_nxt = ST_DDEN;
      ST_DDEN:  st_nxt = ST_DWAIT;
      ST_DWAIT: if (drsp.done) st_nxt = ST_OUT;
      ST_OUT:   if (out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (st_r == ST_IDLE);
    out_tvalid = (st_r == ST_OUT);
    dreq.start     = 1'b0;
    dreq.want_quot = 1'b0;
    dreq.dividend  = x_r;
    dreq.divisor   = y_r;
    case (st_r)
      ST_GCD: dreq.start = (y_r != '0);
      ST_DNUM: begin
        dreq.start = 1'b1; dreq.want_quot = 1'b1;
        dreq.dividend = num_r; dreq.divisor = x_r;
      end
      ST_DDEN: begin
        dreq.start = 1'b1; dreq.want_quot = 1'b1;
        dreq.dividend = den_r; dreq.divisor = x_r;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        op_r <= in_tdata[2:0];
        an_r <= sx(in_tdata[34:3]);
        ad_r <= sx(in_tdata[66:35]);
        bn_r <= sx(in_tdata[98:67]);
        bd_r <= sx(in_tdata[130:99]);
      end
      ST_MUL1: p_r <= prod;
      ST_MUL2: q_r <= prod;
      ST_MUL3: begin d_r <= prod; end
      ST_FORM: begin
        ord_r <= ORD_EQ; flt_r <= FLT_OK; num_r <= '0; den_r <= '0;
        case (op_r)
          OP_ADD: begin
            num_r <= sum; den_r <= d_r; x_r <= sum; y_r <= d_r;
            if (ovf_add) flt_r <= FLT_OVF;
          end
          OP_SUB: begin
            num_r <= dif; den_r <= d_r; x_r <= dif; y_r <= d_r;
            if (ovf_sub) flt_r <= FLT_OVF;
          end
          OP_MUL: begin num_r <= prod; den_r <= d_r; x_r <= prod; y_r <= d_r; end
          OP_DIV: begin num_r <= p_r; den_r <= q_r; x_r <= p_r; y_r <= q_r; end
          OP_ABS: begin
            num_r <= an_r[DW-1] ? -an_r : an_r;
            den_r <= ad_r[DW-1] ? -ad_r : ad_r;
            x_r   <= an_r[DW-1] ? -an_r : an_r;
            y_r   <= ad_r[DW-1] ? -ad_r : ad_r;
          end
          OP_CMP: begin
            if (an_r == bn_r && ad_r == bd_r) ord_r <= ORD_EQ;
            else if ($signed(p_r) < $signed(q_r)) ord_r <= ORD_LT;
            else ord_r <= ORD_GT;
          end
          default: ord_r <= ORD_EQ;
        endcase
      end
      ST_GCD: if (y_r == '0 && x_r == '0) flt_r <= FLT_ZERO;
      ST_GWAIT: if (drsp.done) begin x_r <= y_r; y_r <= drsp.result; end
      ST_NWAIT: if (drsp.done) num_r <= drsp.result;
      ST_DWAIT: if (drsp.done) den_r <= drsp.result;
      default: ;
    endcase
  end

  assign out_tdata = {4'b0, flt_r, ord_r, den_r, num_r};

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result held");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_div_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !drsp.busy) else $error("divider busy at output");
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && op_r == OP_CMP |-> flt_r == FLT_OK)
    else $error("compare faulted");
`endif

endmodule
`default_nettype wire
